### rtl/uitfr_pkg.sv
// Shared types and constants for the idle-timeout UART frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package uitfr_pkg;

  // Default ring depth and idle reload after reset
  localparam int unsigned DepthDefault    = 256;
  localparam int unsigned IdleW           = 16;
  localparam logic [IdleW-1:0] IdleReset  = 16'd10;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_POP     = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  // Result fields from the controller, except the memory read data
  typedef struct packed {
    logic       frame_ready;
    logic [7:0] frame_length;
    logic       read_valid;
    logic       byte_taken;
  } result_t;

endpackage

`default_nettype wire

### rtl/uitfr_ring.sv
// Byte ring storage: one write port, one read port with registered data.
// Depends on uitfr_pkg for the default depth; sized by DEPTH.
`default_nettype none

module uitfr_ring
  import uitfr_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  // Write a stored byte
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read of the addressed byte
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/uitfr_ctrl.sv
// Request controller: ring pointers, idle counter, frame flag, config register.
// Depends on uitfr_pkg; drives the ports of uitfr_ring.
`default_nettype none

module uitfr_ctrl
  import uitfr_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(2 * DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_i,
  input  wire kind_e            kind_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             cfg_we_i,
  input  wire logic [IdleW-1:0] cfg_data_i,
  output logic                  wr_en_o,
  output logic      [AW-1:0]    wr_addr_o,
  output logic      [7:0]       wr_data_o,
  output logic                  rd_en_o,
  output logic      [AW-1:0]    rd_addr_o,
  output logic                  done_o,
  output result_t               result_o
);

  localparam logic [CW:0]   TwoDepth = (CW+1)'(2 * DEPTH);
  localparam logic [CW:0]   DepthX   = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] CntLast  = CW'(2 * DEPTH - 1);

  logic [CW-1:0]    wr_cnt_q, wr_cnt_d;
  logic [CW-1:0]    rd_cnt_q, rd_cnt_d;
  logic [IdleW-1:0] idle_q, idle_d;
  logic [IdleW-1:0] reload_q;
  logic [AW-1:0]    len_q, len_d;
  logic             pend_q, pend_d;
  logic             done_q;
  result_t          res_q, res_d;

  logic [CW:0]   fill;
  logic [AW-1:0] fill_mod;
  logic [CW:0]   fill_inc;
  logic          take_ok;
  logic          store;
  logic          pop_ok;

  // Fill level and ring indexes from the pointers
  always_comb begin
    fill = {1'b0, wr_cnt_q} + ((wr_cnt_q < rd_cnt_q) ? TwoDepth : '0) - {1'b0, rd_cnt_q};
    fill_mod = (fill == DepthX) ? '0 : fill[AW-1:0];
    fill_inc = fill + (CW+1)'(1);
    wr_addr_o = ({1'b0, wr_cnt_q} >= DepthX) ? AW'({1'b0, wr_cnt_q} - DepthX)
                                             : AW'(wr_cnt_q);
    rd_addr_o = ({1'b0, rd_cnt_q} >= DepthX) ? AW'({1'b0, rd_cnt_q} - DepthX)
                                             : AW'(rd_cnt_q);
    wr_data_o = rx_byte_i;
  end

  // Decide what the request does
  always_comb begin
    take_ok = req_i && (kind_i == KIND_BYTE) && !pend_q && (rx_byte_i != 8'd0) &&
              ((fill_mod == '0) || (idle_q != '0));
    store   = take_ok && (fill < DepthX);
    pop_ok  = req_i && (kind_i == KIND_POP) && (fill != '0);
    wr_en_o = store;
    rd_en_o = pop_ok;
  end

  // Next state
  always_comb begin
    wr_cnt_d = wr_cnt_q;
    rd_cnt_d = rd_cnt_q;
    idle_d   = idle_q;
    len_d    = len_q;
    pend_d   = pend_q;
    if (req_i) begin
      unique case (kind_i)
        KIND_TICK: begin
          if (idle_q != '0) begin
            idle_d = idle_q - IdleW'(1);
          end else if ((len_q != '0) && !pend_q) begin
            pend_d = 1'b1;
          end
        end
        KIND_BYTE: begin
          if (take_ok) begin
            idle_d = reload_q;
            if (store) begin
              wr_cnt_d = (wr_cnt_q == CntLast) ? '0 : wr_cnt_q + CW'(1);
              len_d    = (fill_inc == DepthX) ? '0 : fill_inc[AW-1:0];
            end else begin
              len_d = fill_mod;
            end
          end
        end
        KIND_POP: begin
          if (pop_ok) begin
            rd_cnt_d = (rd_cnt_q == CntLast) ? '0 : rd_cnt_q + CW'(1);
          end
        end
        KIND_RELEASE: begin
          pend_d = 1'b0;
        end
        default: begin
          pend_d = pend_q;
        end
      endcase
    end
  end

  // Result fields after the request
  always_comb begin
    res_d.frame_ready  = pend_d;
    res_d.frame_length = 8'(len_d);
    res_d.read_valid   = pop_ok;
    res_d.byte_taken   = store;
  end

  // Hold state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q <= '0;
      rd_cnt_q <= '0;
      idle_q   <= '0;
      len_q    <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      reload_q <= IdleReset;
    end else begin
      wr_cnt_q <= wr_cnt_d;
      rd_cnt_q <= rd_cnt_d;
      idle_q   <= idle_d;
      len_q    <= len_d;
      pend_q   <= pend_d;
      done_q   <= req_i;
      if (cfg_we_i) begin
        reload_q <= cfg_data_i;
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (req_i) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // Ring never holds more than its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= DepthX)
    else $error("ring fill exceeds depth");

  // A result never reports both a stored byte and a popped byte
  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(res_q.read_valid && res_q.byte_taken))
    else $error("result carries both pop and store");

  // Frame flag only rises after a tick request
  a_pend_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(req_i && (kind_i == KIND_TICK)))
    else $error("frame flag set without tick");

  // Pointers do not move without a request
  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i |=> ($stable(wr_cnt_q) && $stable(rd_cnt_q)))
    else $error("ring pointer moved while idle");

endmodule

`default_nettype wire

### rtl/uart_idle_timeout_frame_receiver.sv
// Top level of the idle-timeout UART frame receiver.
// Depends on uitfr_pkg, uitfr_ctrl and uitfr_ring.
`default_nettype none

// Each request (tick, received byte, pop, release) is taken on an edge with
// start_i high and produces exactly one result, shown with done_o high for the
// single cycle that follows; the receiver cannot stall that result, so it must
// sample it then. busy_o stays low: one request per cycle is accepted, since
// every request needs at most one access to the ring memory (a write for a
// stored byte or a read for a pop) and the memory's registered read data is
// matched by registering the results as well. No clearing pass
// runs after reset: a pop only ever reads ring entries that were written. The
// idle reload register may be written through the cfg channel, which is always
// ready, while no request is in flight.
module uart_idle_timeout_frame_receiver
  import uitfr_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       kind_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [IdleW-1:0] cfg_data_i,
  output logic                  done_o,
  output logic                  frame_ready_o,
  output logic      [7:0]       frame_length_o,
  output logic      [7:0]       read_byte_o,
  output logic                  read_valid_o,
  output logic                  byte_taken_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic          req;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  result_t       result;

  // Accept every request; the ring port is free each cycle
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign req         = start_i && !busy_o;

  uitfr_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .kind_i     (kind_e'(kind_i)),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .done_o     (done_o),
    .result_o   (result)
  );

  uitfr_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Drive result ports; drop the read data unless a pop found a byte
  assign frame_ready_o  = result.frame_ready;
  assign frame_length_o = result.frame_length;
  assign read_valid_o   = result.read_valid;
  assign byte_taken_o   = result.byte_taken;
  assign read_byte_o    = result.read_valid ? rd_data : 8'd0;

endmodule

`default_nettype wire
